// ===== rtl/core/zbk_pkg.sv =====
// ----------------------------------------------------------------------------
// zbk_pkg
// Shared types, board constants and the fixed random word table used by the
// board key datapath.
// ----------------------------------------------------------------------------
package zbk_pkg;

  localparam int SQUARES     = 49;
  localparam int BOARD_WIDTH = 7;
  localparam int ROWS        = SQUARES / BOARD_WIDTH;
  localparam int SIDE_STRIDE = SQUARES;
  localparam int TURN_BASE   = 2 * SQUARES;
  localparam int NUM_WORDS   = TURN_BASE + 2;
  localparam int KEY_W       = 64;
  localparam int SQ_W        = 6;
  localparam int ROW_W       = 3;

  typedef logic [SQUARES-1:0] board_t;
  typedef logic [KEY_W-1:0]   key_t;

  // Request codes
  typedef enum logic {
    REQ_FULL   = 1'b0,
    REQ_UPDATE = 1'b1
  } req_t;

  // Move kinds; the spare code behaves as a pass
  typedef enum logic [1:0] {
    MV_PASS = 2'd0,
    MV_STEP = 2'd1,
    MV_JUMP = 2'd2
  } move_t;

  // Select masks and seed handed from the mask stage to the lanes
  typedef struct packed {
    logic   valid;
    board_t wmask;
    board_t bmask;
    key_t   seed;
  } zbk_mask_t;

  // Mask of the squares in one board column
  function automatic board_t col_mask(input int col);
    board_t m;
    m = '0;
    for (int r = 0; r < ROWS; r++) begin
      m[r*BOARD_WIDTH + col] = 1'b1;
    end
    return m;
  endfunction

  localparam board_t COL_FIRST = col_mask(0);
  localparam board_t COL_LAST  = col_mask(BOARD_WIDTH - 1);

  localparam key_t ZBK_WORDS [0:NUM_WORDS-1] = '{
    64'h9D39247E33776D41, 64'h2AF7398005AAA5C7, 64'h44DB015024623547,
    64'h9C15F73E62A76AE2, 64'h75834465489C0C89, 64'h3290AC3A203001BF,
    64'h0FBBAD1F61042279, 64'hE83A908FF2FB60CA, 64'h0D7E765D58755C10,
    64'h1A083822CEAFE02D, 64'h9605D5F0E25EC3B0, 64'hD021FF5CD13A2ED5,
    64'h40BDF15D4A672E32, 64'h011355146FD56395, 64'h5DB4832046F3D9E5,
    64'h239F8B2D7FF719CC, 64'h05D1A1AE85B49AA1, 64'h679F848F6E8FC971,
    64'h7449BBFF801FED0B, 64'h7D11CDB1C3B7ADF0, 64'h82C7709E781EB7CC,
    64'hF3218F1C9510786C, 64'h331478F3AF51BBE6, 64'h4BB38DE5E7219443,
    64'hAA649C6EBCFD50FC, 64'h8DBD98A352AFD40B, 64'h87D2074B81D79217,
    64'h19F3C751D3E92AE1, 64'hB4AB30F062B19ABF, 64'h7B0500AC42047AC4,
    64'hC9452CA81A09D85D, 64'h24AA6C514DA27500, 64'h4C9F34427501B447,
    64'h14A68FD73C910841, 64'hA71B9B83461CBD93, 64'h03488B95B0F1850F,
    64'h637B2B34FF93C040, 64'h09D1BC9A3DD90A94, 64'h3575668334A1DD3B,
    64'h735E2B97A4C45A23, 64'h18727070F1BD400B, 64'h1FCBACD259BF02E7,
    64'hD310A7C2CE9B6555, 64'hBF983FE0FE5D8244, 64'h9F74D14F7454A824,
    64'h51EBDC4AB9BA3035, 64'h5C82C505DB9AB0FA, 64'hFCF7FE8A3430B241,
    64'h3253A729B9BA3DDE, 64'h8C74C368081B3075, 64'hB9BC6C87167C33E7,
    64'h7EF48F2B83024E20, 64'h11D505D4C351BD7F, 64'h6568FCA92C76A243,
    64'h4DE0B0F40F32A7B8, 64'h96D693460CC37E5D, 64'h42E240CB63689F2F,
    64'h6D2BDCDAE2919661, 64'h42880B0236E4D951, 64'h5F0F4A5898171BB6,
    64'h39F890F579F92F88, 64'h93C5B5F47356388B, 64'h63DC359D8D231B78,
    64'hEC16CA8AEA98AD76, 64'h5355F900C2A82DC7, 64'h07FB9F855A997142,
    64'h5093417AA8A7ED5E, 64'h7BCBC38DA25A7F3C, 64'h19FC8A768CF4B6D4,
    64'h637A7780DECFC0D9, 64'h8249A47AEE0E41F7, 64'h79AD695501E7D1E8,
    64'h14ACBAF4777D5776, 64'hF145B6BECCDEA195, 64'hDABF2AC8201752FC,
    64'h24C3C94DF9C8D3F6, 64'hBB6E2924F03912EA, 64'h0CE26C0B95C980D9,
    64'hA49CD132BFBF7CC4, 64'hE99D662AF4243939, 64'h27E6AD7891165C3F,
    64'h8535F040B9744FF1, 64'h54B3F4FA5F40D873, 64'h72B12C32127FED2B,
    64'hEE954D3C7B411F47, 64'h9A85AC909A24EAA1, 64'h70AC4CD9F04F21F5,
    64'hF9B89D3E99A075C2, 64'h87B3E2B2B5C907B1, 64'hA366E5B8C54F48B8,
    64'hAE4A9346CC3F7CF2, 64'h1920C04D47267BBD, 64'h87BF02C6B49E2AE9,
    64'h092237AC237F3859, 64'hFF07F64EF8ED14D0, 64'h8DE8DCA9F03CC54E,
    64'h9C1633264DB49C89, 64'hB3F22C3D0B0B38ED, 64'h390E5FB44D01144B,
    64'h5BFEA5B4712768E9
  };

  localparam key_t TURN_BOTH = ZBK_WORDS[TURN_BASE] ^ ZBK_WORDS[TURN_BASE + 1];

endpackage

// ===== rtl/core/zobrist_board_key.sv =====
// ----------------------------------------------------------------------------
// zobrist_board_key
// Zobrist key of a 7x7 two-color board, full or incremental, one request per
// clock.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction is taken at a rising edge with start high and busy
//   low. req_type selects a full key from white_stones/black_stones and
//   side_to_move, or an update of old_key by move_kind, from_square and
//   to_square (captures use the opponent stones given with the request).
//   Each request yields one new_key, shown for exactly one cycle with done
//   high; there is no way to hold it off, so capture it when done is seen.
//   done is raised once the request has passed the mask stage, the row
//   lanes and the merge stage, in that order. Throughput: one request every
//   cycle; busy is low whenever reset is released, as the three pipeline
//   stages each take a new request at every edge.
//   Reset (rst, synchronous) drops all requests in flight; busy is high
//   while rst is asserted.
// ----------------------------------------------------------------------------
module zobrist_board_key import zbk_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic            req_type,
  input  logic [48:0]     white_stones,
  input  logic [48:0]     black_stones,
  input  logic            side_to_move,
  input  logic [63:0]     old_key,
  input  logic [1:0]      move_kind,
  input  logic [5:0]      from_square,
  input  logic [5:0]      to_square,
  output logic [63:0]     new_key,
  output logic            done
);

  zbk_mask_t                  mask;
  logic [ROWS-1:0][KEY_W-1:0] parts;
  key_t                       seed_d;
  logic                       valid_d;

  assign busy = rst;

  // Mask stage
  zbk_mask u_mask (
    .clk          (clk),
    .rst          (rst),
    .accept       (start & ~busy),
    .req_type     (req_type),
    .white_stones (white_stones),
    .black_stones (black_stones),
    .side_to_move (side_to_move),
    .old_key      (old_key),
    .move_kind    (move_kind),
    .from_square  (from_square),
    .to_square    (to_square),
    .mask         (mask)
  );

  // One lane per board row
  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    zbk_lane u_lane (
      .clk   (clk),
      .row   (ROW_W'(r)),
      .wbits (mask.wmask[r*BOARD_WIDTH +: BOARD_WIDTH]),
      .bbits (mask.bmask[r*BOARD_WIDTH +: BOARD_WIDTH]),
      .part  (parts[r])
    );
  end

  // Seed and valid follow the lanes by one stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d <= 1'b0;
    end else begin
      valid_d <= mask.valid;
    end
    seed_d <= mask.seed;
  end

  // Merge stage
  zbk_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .valid   (valid_d),
    .seed    (seed_d),
    .parts   (parts),
    .new_key (new_key),
    .done    (done)
  );

endmodule

// ===== rtl/core/zbk_mask.sv =====
// ----------------------------------------------------------------------------
// zbk_mask
// Turns one request into per-square select masks for both colors and a seed
// key, registered for the lanes.
// ----------------------------------------------------------------------------
module zbk_mask import zbk_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            req_type,
  input  board_t          white_stones,
  input  board_t          black_stones,
  input  logic            side_to_move,
  input  key_t            old_key,
  input  logic [1:0]      move_kind,
  input  logic [SQ_W-1:0] from_square,
  input  logic [SQ_W-1:0] to_square,
  output zbk_mask_t       mask
);

  localparam board_t ONE = board_t'(1);

  board_t    to_oh;
  board_t    from_oh;
  board_t    nbr;
  board_t    cap;
  board_t    mv;
  logic      is_move;
  zbk_mask_t mask_next;

  // One-hot squares; an out-of-range square shifts out to zero
  assign to_oh   = ONE << to_square;
  assign from_oh = ONE << from_square;

  // Eight-neighbor mask of the destination, column wrap removed
  assign nbr = ((to_oh << 1) & ~COL_FIRST) | ((to_oh >> 1) & ~COL_LAST)
             | (to_oh << BOARD_WIDTH) | (to_oh >> BOARD_WIDTH)
             | ((to_oh << (BOARD_WIDTH + 1)) & ~COL_FIRST)
             | ((to_oh << (BOARD_WIDTH - 1)) & ~COL_LAST)
             | ((to_oh >> (BOARD_WIDTH + 1)) & ~COL_LAST)
             | ((to_oh >> (BOARD_WIDTH - 1)) & ~COL_FIRST);

  // Mask build
  always_comb begin
    case (move_kind)
      MV_STEP, MV_JUMP: is_move = 1'b1;
      default:          is_move = 1'b0;
    endcase
    cap = '0;
    mv  = '0;
    if (is_move) begin
      cap = nbr & (side_to_move ? white_stones : black_stones);
      mv  = to_oh ^ ((move_kind == MV_JUMP) ? from_oh : '0);
    end
    mask_next.valid = accept;
    if (req_type == REQ_FULL) begin
      mask_next.wmask = white_stones;
      mask_next.bmask = black_stones;
      mask_next.seed  = ZBK_WORDS[TURN_BASE + int'(side_to_move)];
    end else begin
      mask_next.wmask = cap ^ (side_to_move ? '0 : mv);
      mask_next.bmask = cap ^ (side_to_move ? mv : '0);
      mask_next.seed  = old_key ^ TURN_BOTH;
    end
  end

  // Stage register: valid under reset, payload free
  always_ff @(posedge clk) begin
    if (rst) begin
      mask.valid <= 1'b0;
    end else begin
      mask.valid <= mask_next.valid;
    end
    mask.wmask <= mask_next.wmask;
    mask.bmask <= mask_next.bmask;
    mask.seed  <= mask_next.seed;
  end

endmodule

// ===== rtl/core/zbk_lane.sv =====
// ----------------------------------------------------------------------------
// zbk_lane
// One board row: XORs the words of the selected squares of both colors and
// registers the partial key.
// ----------------------------------------------------------------------------
module zbk_lane import zbk_pkg::*; (
  input  logic                   clk,
  input  logic [ROW_W-1:0]       row,
  input  logic [BOARD_WIDTH-1:0] wbits,
  input  logic [BOARD_WIDTH-1:0] bbits,
  output key_t                   part
);

  key_t acc;

  // Masked XOR over the row's fourteen words
  always_comb begin
    int sq;
    acc = '0;
    for (int i = 0; i < BOARD_WIDTH; i++) begin
      sq = int'(row) * BOARD_WIDTH + i;
      if (wbits[i]) acc = acc ^ ZBK_WORDS[sq];
      if (bbits[i]) acc = acc ^ ZBK_WORDS[SIDE_STRIDE + sq];
    end
  end

  always_ff @(posedge clk) begin
    part <= acc;
  end

endmodule

// ===== rtl/core/zbk_merge.sv =====
// ----------------------------------------------------------------------------
// zbk_merge
// Folds the row partials into the seed key and presents the result with its
// strobe.
// ----------------------------------------------------------------------------
module zbk_merge import zbk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  input  key_t                 seed,
  input  logic [ROWS-1:0][KEY_W-1:0] parts,
  output key_t                 new_key,
  output logic                 done
);

  key_t key_next;

  // XOR tree over the lanes
  always_comb begin
    key_next = seed;
    for (int r = 0; r < ROWS; r++) begin
      key_next = key_next ^ parts[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
    new_key <= key_next;
  end

endmodule

// ===== tb/tb_zobrist_board_key.sv =====
// ----------------------------------------------------------------------------
// tb_zobrist_board_key
// Self-checking bench for the board key block. A driver walks a queue of
// full and incremental key requests with random gaps, and a monitor checks
// every new_key against a key computed here from an independent word table.
// ----------------------------------------------------------------------------
module tb_zobrist_board_key;
  import zbk_pkg::*;

  // Spare move code, handled as a pass
  localparam logic [1:0] MV_SPARE   = 2'd3;
  localparam int         QUIET_MAX  = 200;
  localparam int         TAIL_WAIT  = 8;
  localparam board_t     FULL_BOARD = '1;

  // Random words: one per stone and square, then the two turn words
  localparam key_t KEY_WORDS [0:99] = '{
    64'h9D39247E33776D41, 64'h2AF7398005AAA5C7, 64'h44DB015024623547,
    64'h9C15F73E62A76AE2, 64'h75834465489C0C89, 64'h3290AC3A203001BF,
    64'h0FBBAD1F61042279, 64'hE83A908FF2FB60CA, 64'h0D7E765D58755C10,
    64'h1A083822CEAFE02D, 64'h9605D5F0E25EC3B0, 64'hD021FF5CD13A2ED5,
    64'h40BDF15D4A672E32, 64'h011355146FD56395, 64'h5DB4832046F3D9E5,
    64'h239F8B2D7FF719CC, 64'h05D1A1AE85B49AA1, 64'h679F848F6E8FC971,
    64'h7449BBFF801FED0B, 64'h7D11CDB1C3B7ADF0, 64'h82C7709E781EB7CC,
    64'hF3218F1C9510786C, 64'h331478F3AF51BBE6, 64'h4BB38DE5E7219443,
    64'hAA649C6EBCFD50FC, 64'h8DBD98A352AFD40B, 64'h87D2074B81D79217,
    64'h19F3C751D3E92AE1, 64'hB4AB30F062B19ABF, 64'h7B0500AC42047AC4,
    64'hC9452CA81A09D85D, 64'h24AA6C514DA27500, 64'h4C9F34427501B447,
    64'h14A68FD73C910841, 64'hA71B9B83461CBD93, 64'h03488B95B0F1850F,
    64'h637B2B34FF93C040, 64'h09D1BC9A3DD90A94, 64'h3575668334A1DD3B,
    64'h735E2B97A4C45A23, 64'h18727070F1BD400B, 64'h1FCBACD259BF02E7,
    64'hD310A7C2CE9B6555, 64'hBF983FE0FE5D8244, 64'h9F74D14F7454A824,
    64'h51EBDC4AB9BA3035, 64'h5C82C505DB9AB0FA, 64'hFCF7FE8A3430B241,
    64'h3253A729B9BA3DDE, 64'h8C74C368081B3075, 64'hB9BC6C87167C33E7,
    64'h7EF48F2B83024E20, 64'h11D505D4C351BD7F, 64'h6568FCA92C76A243,
    64'h4DE0B0F40F32A7B8, 64'h96D693460CC37E5D, 64'h42E240CB63689F2F,
    64'h6D2BDCDAE2919661, 64'h42880B0236E4D951, 64'h5F0F4A5898171BB6,
    64'h39F890F579F92F88, 64'h93C5B5F47356388B, 64'h63DC359D8D231B78,
    64'hEC16CA8AEA98AD76, 64'h5355F900C2A82DC7, 64'h07FB9F855A997142,
    64'h5093417AA8A7ED5E, 64'h7BCBC38DA25A7F3C, 64'h19FC8A768CF4B6D4,
    64'h637A7780DECFC0D9, 64'h8249A47AEE0E41F7, 64'h79AD695501E7D1E8,
    64'h14ACBAF4777D5776, 64'hF145B6BECCDEA195, 64'hDABF2AC8201752FC,
    64'h24C3C94DF9C8D3F6, 64'hBB6E2924F03912EA, 64'h0CE26C0B95C980D9,
    64'hA49CD132BFBF7CC4, 64'hE99D662AF4243939, 64'h27E6AD7891165C3F,
    64'h8535F040B9744FF1, 64'h54B3F4FA5F40D873, 64'h72B12C32127FED2B,
    64'hEE954D3C7B411F47, 64'h9A85AC909A24EAA1, 64'h70AC4CD9F04F21F5,
    64'hF9B89D3E99A075C2, 64'h87B3E2B2B5C907B1, 64'hA366E5B8C54F48B8,
    64'hAE4A9346CC3F7CF2, 64'h1920C04D47267BBD, 64'h87BF02C6B49E2AE9,
    64'h092237AC237F3859, 64'hFF07F64EF8ED14D0, 64'h8DE8DCA9F03CC54E,
    64'h9C1633264DB49C89, 64'hB3F22C3D0B0B38ED, 64'h390E5FB44D01144B,
    64'h5BFEA5B4712768E9
  };

  // One key request plus the idle cycles ahead of it
  typedef struct {
    req_t       req;
    board_t     white;
    board_t     black;
    logic       side;
    key_t       old_key;
    logic [1:0] kind;
    logic [5:0] from_sq;
    logic [5:0] to_sq;
    int         gap;
    bit         drain;
  } key_req_t;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  key_t new_key;

  key_req_t cur = '{REQ_FULL, '0, '0, 1'b0, '0, 2'd0, 6'd0, 6'd0, 0, 1'b0};
  key_req_t pending [$];
  key_t     keys_due [$];
  int       idle_cnt    = 0;
  int       quiet_cnt   = 0;
  int       mismatches  = 0;

  always #1 clk = ~clk;

  zobrist_board_key uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (cur.req),
    .white_stones (cur.white),
    .black_stones (cur.black),
    .side_to_move (cur.side),
    .old_key      (cur.old_key),
    .move_kind    (cur.kind),
    .from_square  (cur.from_sq),
    .to_square    (cur.to_sq),
    .new_key      (new_key),
    .done         (done)
  );

  // Eight-neighbour mask of a square on the row-major board
  function automatic board_t adjacent_squares(input int sq);
    board_t m;
    int r, c, nr, nc;
    m = '0;
    r = sq / BOARD_WIDTH;
    c = sq % BOARD_WIDTH;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = r + dr;
        nc = c + dc;
        if (!(dr == 0 && dc == 0) && nr >= 0 && nc >= 0 &&
            nr < BOARD_WIDTH && nc < BOARD_WIDTH) begin
          m[nr*BOARD_WIDTH + nc] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  // Key that a request must produce
  function automatic key_t board_key(input key_req_t r);
    key_t   k;
    board_t flips;
    int     base;
    base = r.side ? SQUARES : 0;
    if (r.req == REQ_FULL) begin
      k = KEY_WORDS[2*SQUARES + r.side];
      for (int sq = 0; sq < SQUARES; sq++) begin
        if (r.white[sq]) k ^= KEY_WORDS[sq];
        if (r.black[sq]) k ^= KEY_WORDS[SQUARES + sq];
      end
    end else begin
      k = r.old_key ^ KEY_WORDS[2*SQUARES] ^ KEY_WORDS[2*SQUARES + 1];
      if (r.kind == MV_STEP || r.kind == MV_JUMP) begin
        if (r.kind == MV_JUMP && r.from_sq < SQUARES) k ^= KEY_WORDS[base + r.from_sq];
        if (r.to_sq < SQUARES) begin
          k ^= KEY_WORDS[base + r.to_sq];
          // opponent stones next to the destination change color
          flips = adjacent_squares(r.to_sq) & (r.side ? r.white : r.black);
          for (int sq = 0; sq < SQUARES; sq++) begin
            if (flips[sq]) k ^= KEY_WORDS[sq] ^ KEY_WORDS[SQUARES + sq];
          end
        end
      end
    end
    return k;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task automatic queue_req(input req_t req, input board_t white, input board_t black,
                           input logic side, input key_t old_key, input logic [1:0] kind,
                           input logic [5:0] from_sq, input logic [5:0] to_sq,
                           input int gap, input bit drain);
    key_req_t r;
    r = '{req, white, black, side, old_key, kind, from_sq, to_sq, gap, drain};
    pending.push_back(r);
  endtask

  function automatic board_t random_board();
    board_t b;
    b = board_t'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: b = b & board_t'({$urandom, $urandom});
      1: b = b | board_t'({$urandom, $urandom});
      default: ;
    endcase
    return b;
  endfunction

  function automatic logic [5:0] random_square();
    if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, SQUARES - 1));
  endfunction

  // Driver: present queued requests, count a transaction at start && !busy
  always @(posedge clk) begin : driver
    key_req_t nxt;
    logic     fire;
    logic     go;
    if (rst) begin
      start    <= 1'b0;
      idle_cnt <= 0;
    end else begin
      fire = start && !busy;
      if (fire) keys_due.push_back(board_key(cur));
      if (!start || fire) begin
        go = 1'b0;
        if (pending.size() > 0) begin
          go = (idle_cnt >= pending[0].gap) && !(pending[0].drain && keys_due.size() != 0);
        end
        if (go) begin
          nxt = pending.pop_front();
          cur      <= nxt;
          start    <= 1'b1;
          idle_cnt <= 0;
        end else begin
          start <= 1'b0;
          if (pending.size() > 0) idle_cnt <= idle_cnt + 1;
        end
      end
    end
  end

  // Monitor: each done strobe carries one result transaction
  always @(posedge clk) begin : monitor
    key_t want;
    if (!rst && done) begin
      if (keys_due.size() == 0) begin
        report_mismatch($sformatf("unexpected new_key %h", new_key));
      end else begin
        want = keys_due.pop_front();
        if (new_key !== want) begin
          report_mismatch($sformatf("new_key %h, expected %h", new_key, want));
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt >= QUIET_MAX) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    key_req_t r;
    int       gap;
    bit       burst;
    rst <= 1'b1;

    // Directed: empty and full boards, both turns
    queue_req(REQ_FULL, '0, '0, 1'b0, '0, MV_PASS, 6'd0, 6'd0, 0, 1'b0);
    queue_req(REQ_FULL, '0, '0, 1'b1, '0, MV_PASS, 6'd0, 6'd0, 0, 1'b0);
    queue_req(REQ_FULL, FULL_BOARD, '0, 1'b0, '0, MV_PASS, 6'd0, 6'd0, 0, 1'b0);
    queue_req(REQ_FULL, '0, FULL_BOARD, 1'b1, '0, MV_PASS, 6'd0, 6'd0, 0, 1'b0);
    // full request ignores old key and move fields
    queue_req(REQ_FULL, FULL_BOARD, FULL_BOARD, 1'b0, '1, MV_SPARE, 6'd63, 6'd63, 1, 1'b0);
    // passes, including the spare move code
    queue_req(REQ_UPDATE, FULL_BOARD, FULL_BOARD, 1'b0, '0, MV_PASS, 6'd24, 6'd24, 0, 1'b0);
    queue_req(REQ_UPDATE, '0, '0, 1'b1, '1, MV_PASS, 6'd0, 6'd0, 2, 1'b0);
    queue_req(REQ_UPDATE, FULL_BOARD, FULL_BOARD, 1'b0, {$urandom, $urandom}, MV_SPARE,
              6'd10, 6'd11, 0, 1'b0);
    // steps to corners and center with every neighbour captured
    queue_req(REQ_UPDATE, '0, FULL_BOARD, 1'b0, {$urandom, $urandom}, MV_STEP,
              6'd0, 6'd0, 0, 1'b0);
    queue_req(REQ_UPDATE, '0, FULL_BOARD, 1'b0, {$urandom, $urandom}, MV_STEP,
              6'd0, 6'd48, 3, 1'b0);
    queue_req(REQ_UPDATE, FULL_BOARD, '0, 1'b1, {$urandom, $urandom}, MV_STEP,
              6'd0, 6'd24, 0, 1'b0);
    // own stones play no part
    queue_req(REQ_UPDATE, FULL_BOARD, FULL_BOARD, 1'b1, {$urandom, $urandom}, MV_STEP,
              6'd0, 6'd6, 0, 1'b0);
    queue_req(REQ_UPDATE, FULL_BOARD, FULL_BOARD, 1'b0, {$urandom, $urandom}, MV_STEP,
              6'd0, 6'd42, 8, 1'b0);
    // jumps corner to corner
    queue_req(REQ_UPDATE, '0, FULL_BOARD, 1'b0, {$urandom, $urandom}, MV_JUMP,
              6'd48, 6'd0, 0, 1'b0);
    queue_req(REQ_UPDATE, FULL_BOARD, '0, 1'b1, {$urandom, $urandom}, MV_JUMP,
              6'd0, 6'd48, 0, 1'b0);
    // off-board squares toggle nothing
    queue_req(REQ_UPDATE, '0, FULL_BOARD, 1'b0, {$urandom, $urandom}, MV_JUMP,
              6'd63, 6'd24, 1, 1'b0);
    queue_req(REQ_UPDATE, FULL_BOARD, '0, 1'b1, {$urandom, $urandom}, MV_JUMP,
              6'd49, 6'd20, 0, 1'b0);
    queue_req(REQ_UPDATE, '0, FULL_BOARD, 1'b0, {$urandom, $urandom}, MV_STEP,
              6'd0, 6'd49, 0, 1'b0);
    queue_req(REQ_UPDATE, FULL_BOARD, FULL_BOARD, 1'b1, {$urandom, $urandom}, MV_JUMP,
              6'd10, 6'd63, 0, 1'b0);
    // no opponent stones, then from equals to; sender holds off first
    queue_req(REQ_UPDATE, FULL_BOARD, '0, 1'b0, {$urandom, $urandom}, MV_STEP,
              6'd0, 6'd30, 0, 1'b1);
    queue_req(REQ_UPDATE, random_board(), random_board(), 1'b0, {$urandom, $urandom},
              MV_JUMP, 6'd17, 6'd17, 0, 1'b0);
    queue_req(REQ_FULL, random_board(), random_board(), 1'b1, {$urandom, $urandom},
              MV_STEP, 6'd5, 6'd5, 4, 1'b0);

    // Random: mostly legal-looking positions, some overlapping boards
    for (int i = 0; i < 530; i++) begin
      burst = ((i / 40) % 3 == 1);
      gap   = burst ? 0 : $urandom_range(0, 8);
      r.req     = ($urandom_range(0, 9) < 4) ? REQ_FULL : REQ_UPDATE;
      r.white   = random_board();
      r.black   = random_board();
      if ($urandom_range(0, 9) < 7) r.black = r.black & ~r.white;
      r.side    = 1'($urandom_range(0, 1));
      r.old_key = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: r.kind = MV_PASS;
        1: r.kind = MV_SPARE;
        2, 3, 4, 5: r.kind = MV_STEP;
        default: r.kind = MV_JUMP;
      endcase
      r.from_sq = random_square();
      r.to_sq   = random_square();
      r.gap     = gap;
      r.drain   = (i % 97 == 50);
      pending.push_back(r);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || start) @(posedge clk);
    while (keys_due.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/zbk_pkg.sv
rtl/core/zbk_mask.sv
rtl/core/zbk_lane.sv
rtl/core/zbk_merge.sv
rtl/core/zobrist_board_key.sv
tb/tb_zobrist_board_key.sv
